### hw/rtl/text_escape_encoder_macros.svh
// Assertion macros for the text escape encoder checker.
`ifndef TEXT_ESCAPE_ENCODER_MACROS_SVH
`define TEXT_ESCAPE_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tee assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tee assertion failed");

`endif

### hw/rtl/tee_pkg.sv
// Shared types and character constants for the text escape encoder.
`default_nettype none

package tee_pkg;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_TCL   = 2'd1;
  localparam logic [1:0] MODE_XML   = 2'd2;
  localparam logic [1:0] MODE_JSON  = 2'd3;

  localparam int unsigned SEQ_BYTES = 6;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // bytes[SEQ_BYTES-1] goes out first
  typedef struct packed {
    logic [SEQ_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
  } seq_t;

  typedef struct packed {
    logic  load;
    seq_t  seq;
    logic  last;
  } load_t;

endpackage

`default_nettype wire

### hw/rtl/tee_escape.sv
// Escape table: maps one byte and the mode to its escaped byte sequence.
`default_nettype none

module tee_escape (
  input  wire logic [1:0]   mode_i,
  input  wire logic [7:0]   char_i,
  output tee_pkg::seq_t     seq_o
);

  logic [7:0] c;

  assign c = char_i;

  always_comb begin
    seq_o.bytes = {c, 40'h0};
    seq_o.len   = 3'd1;
    case (mode_i)
      tee_pkg::MODE_XML: begin
        case (c)
          tee_pkg::CH_DQUOTE: begin
            seq_o.bytes = "&quot;";
            seq_o.len   = 3'd6;
          end
          tee_pkg::CH_SQUOTE: begin
            seq_o.bytes = "&apos;";
            seq_o.len   = 3'd6;
          end
          tee_pkg::CH_LT: begin
            seq_o.bytes = {"&lt;", 16'h0};
            seq_o.len   = 3'd4;
          end
          tee_pkg::CH_GT: begin
            seq_o.bytes = {"&gt;", 16'h0};
            seq_o.len   = 3'd4;
          end
          tee_pkg::CH_AMP: begin
            seq_o.bytes = {"&amp;", 8'h0};
            seq_o.len   = 3'd5;
          end
          default: ;
        endcase
      end
      tee_pkg::MODE_TCL: begin
        if (c inside {tee_pkg::CH_DQUOTE, tee_pkg::CH_DOLLAR, tee_pkg::CH_LBRACE,
                      tee_pkg::CH_RBRACE, tee_pkg::CH_LBRACK, tee_pkg::CH_RBRACK,
                      tee_pkg::CH_BSLASH}) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, c, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_LF) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_N, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_TAB) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_T, 32'h0};
          seq_o.len   = 3'd2;
        end
      end
      tee_pkg::MODE_JSON: begin
        if (c inside {tee_pkg::CH_DQUOTE, tee_pkg::CH_BSLASH, tee_pkg::CH_SLASH}) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, c, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_TAB) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_T, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_BS) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_B, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_LF) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_N, 32'h0};
          seq_o.len   = 3'd2;
        end else if (c == tee_pkg::CH_CR) begin
          seq_o.bytes = {tee_pkg::CH_BSLASH, tee_pkg::CH_R, 32'h0};
          seq_o.len   = 3'd2;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tee_out_stage.sv
// Result register: holds one escaped sequence and shifts it out a byte per transaction.
`default_nettype none

module tee_out_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tee_pkg::load_t ld_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             string_end_o
);

  logic                                  valid_q, valid_d;
  logic [2:0]                            rem_q, rem_d;
  logic [tee_pkg::SEQ_BYTES-1:0][7:0]    buf_q, buf_d;
  logic                                  last_q, last_d;
  logic                                  fire;
  logic                                  fin;

  assign fire   = valid_q && !out_stall_i;
  assign fin    = fire && (rem_q == 3'd1);
  assign free_o = !valid_q || fin;

  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    buf_d   = buf_q;
    last_d  = last_q;
    if (ld_i.load) begin
      valid_d = 1'b1;
      rem_d   = ld_i.seq.len;
      buf_d   = ld_i.seq.bytes;
      last_d  = ld_i.last;
    end else if (fin) begin
      valid_d = 1'b0;
    end else if (fire) begin
      rem_d = rem_q - 3'd1;
      buf_d = buf_q << 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    last_q <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = buf_q[tee_pkg::SEQ_BYTES-1];
  assign run_last_o   = (rem_q == 3'd1);
  assign string_end_o = (rem_q == 3'd1) && last_q;

endmodule

`default_nettype wire

### hw/rtl/text_escape_encoder.sv
// Top level of the text escape encoder: input register, escape table, result register.
//
// Takes one character per input transaction and emits its escaped form one byte per
// output transaction, formatted by the escape mode register (plain, TCL, XML entities,
// JSON). Plain text streams at one character per clock while the output is not stalled.
// An escaped character expands to its escaped length: two bytes for backslash escapes,
// four to six for XML entities. The result register sends one byte per cycle while the
// output is not stalled; the input register takes the next character while the current
// sequence drains. An accepted character passes through the input register, then the
// result register, before its first output byte is presented. The mode register is
// written at any time with cfg_ready_o always high, but should change only while no
// character is in flight.
`default_nettype none

module text_escape_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_end_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_escape_mode_i
);

  logic [1:0]      esc_mode_q;
  logic            s1_valid_q, s1_valid_d;
  tee_pkg::item_t  s1_item_q;
  tee_pkg::seq_t   seq;
  tee_pkg::load_t  ld;
  logic            free;
  logic            in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_mode_q <= tee_pkg::MODE_PLAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      esc_mode_q <= cfg_escape_mode_i;
    end
  end

  assign ld.load     = s1_valid_q && free;
  assign ld.seq      = seq;
  assign ld.last     = s1_item_q.last;
  assign in_stall_o  = s1_valid_q && !free;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (ld.load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.data <= in_byte_i;
      s1_item_q.last <= in_last_i;
    end
  end

  tee_escape u_escape (
    .mode_i (esc_mode_q),
    .char_i (s1_item_q.data),
    .seq_o  (seq)
  );

  tee_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_i         (ld),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

`default_nettype wire

### hw/rtl/tee_checker.sv
// Port-level assertion checker for the text escape encoder, bound to the top level.
`default_nettype none

`include "text_escape_encoder_macros.svh"

module tee_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o,
  input wire logic       string_end_o
);

  `TEE_ASSERT_NOW(a_end_is_run_last, out_valid_o && string_end_o, run_last_o)
  `TEE_ASSERT_NOW(a_stall_needs_busy_out, in_stall_o, out_valid_o)
  `TEE_ASSERT_NEXT(a_run_contiguous, out_valid_o && !out_stall_i && !run_last_o, out_valid_o)
  `TEE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_byte_o) && $stable(run_last_o))

endmodule

bind text_escape_encoder tee_checker u_tee_checker (.*);

`default_nettype wire

### tb/tb_text_escape_encoder.sv
// Self-checking testbench for the text escape encoder across all four escape modes.
`timescale 1ns / 1ps

module tb_text_escape_encoder;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       str_end;
  } out_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_mode = tee_pkg::MODE_PLAIN;

  tee_pkg::item_t char_q[$];
  out_beat_t  escaped_q[$];
  logic [1:0] cur_mode = tee_pkg::MODE_PLAIN;
  logic       in_fire_q = 1'b0;
  logic       quiet = 1'b0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         errors = 0;
  int         cycles = 0;

  logic [7:0] esc_chars [17] = '{tee_pkg::CH_DQUOTE, tee_pkg::CH_SQUOTE, tee_pkg::CH_LT,
                                 tee_pkg::CH_GT, tee_pkg::CH_AMP, tee_pkg::CH_LF,
                                 tee_pkg::CH_TAB, tee_pkg::CH_DOLLAR, tee_pkg::CH_LBRACE,
                                 tee_pkg::CH_RBRACE, tee_pkg::CH_LBRACK, tee_pkg::CH_RBRACK,
                                 tee_pkg::CH_BSLASH, tee_pkg::CH_BS, tee_pkg::CH_CR,
                                 tee_pkg::CH_SLASH, 8'h00};

  text_escape_encoder u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_byte_i         (in_byte),
    .in_last_i         (in_last),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_byte_o        (out_byte),
    .run_last_o        (run_last),
    .string_end_o      (string_end),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_escape_mode_i (cfg_mode)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Expected output bytes for one character in the given mode.
  task automatic expect_escaped(input logic [1:0] mode, input logic [7:0] ch,
                                input logic last);
    logic [7:0] seq[$];
    string      ent;
    out_beat_t  b;
    int         i;
    ent = "";
    case (mode)
      tee_pkg::MODE_XML: begin
        case (ch)
          tee_pkg::CH_DQUOTE: ent = "&quot;";
          tee_pkg::CH_SQUOTE: ent = "&apos;";
          tee_pkg::CH_LT:     ent = "&lt;";
          tee_pkg::CH_GT:     ent = "&gt;";
          tee_pkg::CH_AMP:    ent = "&amp;";
          default: ;
        endcase
      end
      tee_pkg::MODE_TCL: begin
        case (ch)
          tee_pkg::CH_DQUOTE, tee_pkg::CH_DOLLAR, tee_pkg::CH_LBRACE, tee_pkg::CH_RBRACE,
          tee_pkg::CH_LBRACK, tee_pkg::CH_RBRACK,
          tee_pkg::CH_BSLASH: seq = '{tee_pkg::CH_BSLASH, ch};
          tee_pkg::CH_LF:     seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_N};
          tee_pkg::CH_TAB:    seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_T};
          default: ;
        endcase
      end
      tee_pkg::MODE_JSON: begin
        case (ch)
          tee_pkg::CH_DQUOTE, tee_pkg::CH_BSLASH,
          tee_pkg::CH_SLASH: seq = '{tee_pkg::CH_BSLASH, ch};
          tee_pkg::CH_TAB: seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_T};
          tee_pkg::CH_BS:  seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_B};
          tee_pkg::CH_LF:  seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_N};
          tee_pkg::CH_CR:  seq = '{tee_pkg::CH_BSLASH, tee_pkg::CH_R};
          default: ;
        endcase
      end
      default: ;
    endcase
    for (i = 0; i < ent.len(); i++) seq.push_back(ent[i]);
    if (seq.size() == 0) seq.push_back(ch);
    for (i = 0; i < seq.size(); i++) begin
      b.ch       = seq[i];
      b.run_last = (i == seq.size() - 1);
      b.str_end  = b.run_last && last;
      escaped_q.push_back(b);
    end
  endtask

  // input transaction driver
  always @(negedge clk_i) begin : char_driver
    tee_pkg::item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (char_q.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
        it = char_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= it.data;
        in_last  <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 20);
    end
  end

  // predict on accepted input, check accepted output
  always @(posedge clk_i) begin : escape_monitor
    out_beat_t want;
    in_fire_q <= rst_ni && in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) expect_escaped(cur_mode, in_byte, in_last);
    if (rst_ni && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected output byte %h run_last %b string_end %b",
                 $time, out_byte, run_last, string_end);
        errors++;
      end else begin
        want = escaped_q.pop_front();
        if (out_byte !== want.ch) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.ch, out_byte);
          errors++;
        end
        if (run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last, run_last);
          errors++;
        end
        if (string_end !== want.str_end) begin
          $display("%0t: string_end expected %b actual %b", $time, want.str_end, string_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, escaped_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (char_q.size() != 0 || in_valid || escaped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_mode  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cur_mode = mode;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    tee_pkg::item_t it;
    it.data = ch;
    it.last = last;
    char_q.push_back(it);
  endtask

  task automatic push_string(input int len);
    int k;
    logic [7:0] ch;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(1)) ch = esc_chars[$urandom_range(16)];
      else ch = 8'($urandom_range(255));
      push_char(ch, k == len - 1);
    end
  endtask

  initial begin : stimulus
    logic [1:0] phase_mode [8];
    int p;
    int n;
    phase_mode = '{tee_pkg::MODE_JSON, tee_pkg::MODE_PLAIN, tee_pkg::MODE_TCL,
                   tee_pkg::MODE_XML, tee_pkg::MODE_JSON, tee_pkg::MODE_PLAIN,
                   tee_pkg::MODE_TCL, tee_pkg::MODE_XML};
    phase_mode[6] = 2'($urandom_range(3));
    phase_mode[7] = 2'($urandom_range(3));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_mode(tee_pkg::MODE_PLAIN);
    push_char(8'h00, 1'b0);
    push_char(tee_pkg::CH_AMP, 1'b0);
    push_char(8'hff, 1'b1);
    drain();
    write_mode(tee_pkg::MODE_TCL);
    push_char(tee_pkg::CH_DQUOTE, 1'b0);
    push_char(tee_pkg::CH_DOLLAR, 1'b0);
    push_char(tee_pkg::CH_LBRACE, 1'b0);
    push_char(tee_pkg::CH_RBRACE, 1'b0);
    push_char(tee_pkg::CH_LBRACK, 1'b0);
    push_char(tee_pkg::CH_RBRACK, 1'b0);
    push_char(tee_pkg::CH_BSLASH, 1'b0);
    push_char(tee_pkg::CH_LF, 1'b0);
    push_char(tee_pkg::CH_TAB, 1'b1);
    drain();
    write_mode(tee_pkg::MODE_XML);
    push_char(tee_pkg::CH_DQUOTE, 1'b0);
    push_char(tee_pkg::CH_SQUOTE, 1'b0);
    push_char(tee_pkg::CH_LT, 1'b0);
    push_char(tee_pkg::CH_GT, 1'b0);
    push_char(tee_pkg::CH_AMP, 1'b1);
    drain();
    write_mode(tee_pkg::MODE_JSON);
    push_char(tee_pkg::CH_DQUOTE, 1'b0);
    push_char(tee_pkg::CH_BSLASH, 1'b0);
    push_char(tee_pkg::CH_SLASH, 1'b0);
    push_char(tee_pkg::CH_TAB, 1'b0);
    push_char(tee_pkg::CH_BS, 1'b0);
    push_char(tee_pkg::CH_LF, 1'b0);
    push_char(tee_pkg::CH_CR, 1'b1);
    drain();

    for (p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      quiet = (p == 2);
      if (p == 5) hold_req = hold_req + 1;
      n = 0;
      while (n < 62) begin
        push_string($urandom_range(12, 1));
        n = n + char_q.size() - n;
      end
      drain();
      quiet = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
